/* rtl/core/gabt_pkg.sv */
// ----------------------------------------------------------------------------
// gabt_pkg: shared types and constants of the alpha-beta tracker
// Sequencer states, unit status, register codes and magnitude and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package gabt_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned GainW = 16;
  localparam int unsigned LimW  = 31;
  localparam int unsigned DtW   = 16;

  localparam logic [GainW-1:0] AlphaReset  = 16'd32768;
  localparam logic [GainW-1:0] BetaReset   = 16'd6554;
  localparam logic [LimW-1:0]  GateReset   = 31'd2560;
  localparam logic [LimW-1:0]  SpeedReset  = 31'd76800;
  // 0.1 s in Q4.12
  localparam logic [DtW-1:0]   DtDefault   = 16'd410;

  typedef enum logic [1:0] {
    CFG_ALPHA = 2'd0,
    CFG_BETA  = 2'd1,
    CFG_GATE  = 2'd2,
    CFG_SPEED = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PRED_GO,
    S_PRED_WAIT,
    S_INNOV,
    S_SQ_GO,
    S_SQ_WAIT,
    S_LIM_GO,
    S_LIM_WAIT,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_SC_MUL_GO,
    S_SC_MUL_WAIT,
    S_SC_DIV_GO,
    S_SC_DIV_WAIT,
    S_CL_END,
    S_AL_GO,
    S_AL_WAIT,
    S_BE_MUL_GO,
    S_BE_MUL_WAIT,
    S_BE_DIV_GO,
    S_BE_DIV_WAIT,
    S_VLOAD,
    S_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [DataW-1:0] mag32(input logic signed [DataW-1:0] v);
    mag32 = v[DataW-1] ? (32'd0 - v) : v;
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[DataW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/gabt_mul.sv */
// ----------------------------------------------------------------------------
// gabt_mul: bit-serial unsigned multiplier
// 32 x 32 -> 64 bits, one multiplier bit per cycle, shift-and-add.
// ----------------------------------------------------------------------------
`default_nettype none

module gabt_mul (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [31:0]          a_i,
  input  wire logic [31:0]          b_i,
  output gabt_pkg::unit_stat_t      stat_o,
  output logic [63:0]               prod_o
);
  import gabt_pkg::*;

  logic [31:0] a_q;
  logic [63:0] acc_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] sum;

  assign sum = {1'b0, acc_q[63:32]} + (acc_q[0] ? {1'b0, a_q} : 33'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      acc_q <= {32'd0, b_i};
    end else if (busy_q) begin
      acc_q <= {sum, acc_q[31:1]};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign prod_o = acc_q;

endmodule

`default_nettype wire

/* rtl/core/gabt_div.sv */
// ----------------------------------------------------------------------------
// gabt_div: bit-serial restoring divider
// 64 / 32 -> 64-bit quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gabt_div (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [63:0]          dvd_i,
  input  wire logic [31:0]          dvs_i,
  output gabt_pkg::unit_stat_t      stat_o,
  output logic [63:0]               quo_o
);
  import gabt_pkg::*;

  logic [63:0] dvd_q;
  logic [31:0] dvs_q, rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] sh;
  logic        ge;

  assign sh = {rem_q, dvd_q[63]};
  assign ge = sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_i;
      dvs_q <= dvs_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? 32'(sh - {1'b0, dvs_q}) : sh[31:0];
      dvd_q <= {dvd_q[62:0], ge};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quo_o  = dvd_q;

endmodule

`default_nettype wire

/* rtl/core/gabt_sqrt.sv */
// ----------------------------------------------------------------------------
// gabt_sqrt: digit-serial integer square root
// floor(sqrt) of a 64-bit value, two radicand bits and one root bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gabt_sqrt (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [63:0]          x_i,
  output gabt_pkg::unit_stat_t      stat_o,
  output logic [31:0]               root_o
);
  import gabt_pkg::*;

  logic [63:0] x_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [35:0] sh, trial;
  logic        ge;

  assign sh    = {rem_q, x_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? 34'(sh - trial) : sh[33:0];
      root_q <= {root_q[30:0], ge};
      x_q    <= {x_q[61:0], 2'b00};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign root_o = root_q;

endmodule

`default_nettype wire

/* rtl/core/gated_alpha_beta_tracker_3d.sv */
// ----------------------------------------------------------------------------
// gated_alpha_beta_tracker_3d: three-axis gated alpha-beta tracker
// Sequencer over a serial multiplier, divider and square root unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one measurement request:
//   position, velocity, camera flag and Q4.12 time step. Output channel
//   (out_valid_o / out_stall_i) returns the updated estimate, one per request.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
//   must write them only while idle, as the block itself has no guard for this.
//   One request is processed at a time; in_stall_o is high while busy. The
//   work per request depends on the serial units and on the path taken: the
//   camera flag and whether the gate and speed clips apply. The result sits in
//   an output register; a stalled result holds and the sequencer waits at its
//   end until the register is free. Reset clears the estimate, the primed flag
//   and restores register defaults (alpha 0.5, beta 0.1, gate 10 m, speed
//   300 m/s).
// ----------------------------------------------------------------------------
`default_nettype none

module gated_alpha_beta_tracker_3d (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [30:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic signed [31:0] meas_pos_x_i,
  input  wire logic signed [31:0] meas_pos_y_i,
  input  wire logic signed [31:0] meas_pos_z_i,
  input  wire logic signed [31:0] meas_vel_x_i,
  input  wire logic signed [31:0] meas_vel_y_i,
  input  wire logic signed [31:0] meas_vel_z_i,
  input  wire logic        camera_valid_i,
  input  wire logic [15:0] time_step_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [31:0] est_pos_x_o,
  output logic signed [31:0] est_pos_y_o,
  output logic signed [31:0] est_pos_z_o,
  output logic signed [31:0] est_vel_x_o,
  output logic signed [31:0] est_vel_y_o,
  output logic signed [31:0] est_vel_z_o
);
  import gabt_pkg::*;

  state_e state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic primed_q, primed_d, clip_vel_q, clip_vel_d, cam_q, cam_d;
  logic [DtW-1:0] dt_q, dt_d;
  logic [63:0] sum_q, sum_d;
  logic signed [31:0] pos_q [3], pos_d [3];
  logic signed [31:0] vel_q [3], vel_d [3];
  logic signed [31:0] vec_q [3], vec_d [3];
  logic signed [31:0] mp_q [3], mp_d [3];
  logic signed [31:0] est_pos_q [3], est_pos_d [3];
  logic signed [31:0] est_vel_q [3], est_vel_d [3];
  logic out_valid_q, out_valid_d;

  logic [GainW-1:0] alpha_q, beta_q;
  logic [LimW-1:0]  gate_q, speed_q;

  logic mul_start, div_start, sqrt_start;
  logic [31:0] mul_a, mul_b, div_b, sqrt_root;
  logic [63:0] div_a, sqrt_x, mul_prod, div_quo;
  unit_stat_t mul_stat, div_stat, sqrt_stat;

  logic signed [31:0] cur, vel_cur, pos_cur;
  logic [31:0] cur_mag, lim;
  logic signed [63:0] term;
  logic [63:0] qv;

  assign cur     = vec_q[axis_q];
  assign vel_cur = vel_q[axis_q];
  assign pos_cur = pos_q[axis_q];
  assign cur_mag = mag32(cur);
  assign lim     = {1'b0, clip_vel_q ? speed_q : gate_q};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= AlphaReset;
      beta_q  <= BetaReset;
      gate_q  <= GateReset;
      speed_q <= SpeedReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALPHA: alpha_q <= cfg_data_i[GainW-1:0];
        CFG_BETA:  beta_q  <= cfg_data_i[GainW-1:0];
        CFG_GATE:  gate_q  <= cfg_data_i;
        CFG_SPEED: speed_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  gabt_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .stat_o(mul_stat), .prod_o(mul_prod)
  );

  gabt_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dvd_i(div_a), .dvs_i(div_b),
    .stat_o(div_stat), .quo_o(div_quo)
  );

  gabt_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .x_i(sqrt_x),
    .stat_o(sqrt_stat), .root_o(sqrt_root)
  );

  assign sqrt_x = sum_q;

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    primed_d    = primed_q;
    clip_vel_d  = clip_vel_q;
    cam_d       = cam_q;
    dt_d        = dt_q;
    sum_d       = sum_q;
    pos_d       = pos_q;
    vel_d       = vel_q;
    vec_d       = vec_q;
    mp_d        = mp_q;
    est_pos_d   = est_pos_q;
    est_vel_d   = est_vel_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    sqrt_start  = 1'b0;
    mul_a       = cur_mag;
    mul_b       = cur_mag;
    div_a       = mul_prod;
    div_b       = sqrt_root;
    term        = '0;
    qv          = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mp_d[0] = meas_pos_x_i;
          mp_d[1] = meas_pos_y_i;
          mp_d[2] = meas_pos_z_i;
          cam_d   = camera_valid_i;
          dt_d    = (time_step_i == '0) ? DtDefault : time_step_i;
          axis_d  = '0;
          sum_d   = '0;
          if (!primed_q) begin
            primed_d   = 1'b1;
            pos_d[0]   = meas_pos_x_i;
            pos_d[1]   = meas_pos_y_i;
            pos_d[2]   = meas_pos_z_i;
            vel_d[0]   = meas_vel_x_i;
            vel_d[1]   = meas_vel_y_i;
            vel_d[2]   = meas_vel_z_i;
            vec_d[0]   = meas_vel_x_i;
            vec_d[1]   = meas_vel_y_i;
            vec_d[2]   = meas_vel_z_i;
            clip_vel_d = 1'b1;
            state_d    = S_SQ_GO;
          end else begin
            state_d = S_PRED_GO;
          end
        end
      end
      S_PRED_GO: begin
        mul_start = 1'b1;
        mul_a     = mag32(vel_cur);
        mul_b     = {16'd0, dt_q};
        state_d   = S_PRED_WAIT;
      end
      S_PRED_WAIT: begin
        if (mul_stat.done) begin
          qv   = (mul_prod + 64'd2048) >> 12;
          term = vel_cur[31] ? $signed(64'd0 - qv) : $signed(qv);
          pos_d[axis_q] = sat32(64'(pos_cur) + term);
          if (axis_q == 2'd2) begin
            axis_d  = '0;
            state_d = cam_q ? S_INNOV : S_VLOAD;
          end else begin
            axis_d  = axis_q + 2'd1;
            state_d = S_PRED_GO;
          end
        end
      end
      S_INNOV: begin
        for (int i = 0; i < 3; i++) begin
          vec_d[i] = sat32(64'(mp_q[i]) - 64'(pos_q[i]));
        end
        clip_vel_d = 1'b0;
        sum_d      = '0;
        axis_d     = '0;
        state_d    = S_SQ_GO;
      end
      S_SQ_GO: begin
        mul_start = 1'b1;
        state_d   = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (mul_stat.done) begin
          sum_d = sum_q + mul_prod;
          if (axis_q == 2'd2) begin
            axis_d  = '0;
            state_d = S_LIM_GO;
          end else begin
            axis_d  = axis_q + 2'd1;
            state_d = S_SQ_GO;
          end
        end
      end
      S_LIM_GO: begin
        mul_start = 1'b1;
        mul_a     = lim;
        mul_b     = lim;
        state_d   = S_LIM_WAIT;
      end
      S_LIM_WAIT: begin
        if (mul_stat.done) begin
          state_d = (sum_q > mul_prod) ? S_SQRT_GO : S_CL_END;
        end
      end
      S_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_d    = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (sqrt_stat.done) begin
          axis_d  = '0;
          state_d = S_SC_MUL_GO;
        end
      end
      S_SC_MUL_GO: begin
        mul_start = 1'b1;
        mul_b     = lim;
        state_d   = S_SC_MUL_WAIT;
      end
      S_SC_MUL_WAIT: begin
        if (mul_stat.done) begin
          state_d = S_SC_DIV_GO;
        end
      end
      S_SC_DIV_GO: begin
        div_start = 1'b1;
        state_d   = S_SC_DIV_WAIT;
      end
      S_SC_DIV_WAIT: begin
        if (div_stat.done) begin
          vec_d[axis_q] = cur[31] ? $signed(32'd0 - div_quo[31:0])
                                  : $signed(div_quo[31:0]);
          if (axis_q == 2'd2) begin
            axis_d  = '0;
            state_d = S_CL_END;
          end else begin
            axis_d  = axis_q + 2'd1;
            state_d = S_SC_MUL_GO;
          end
        end
      end
      S_CL_END: begin
        axis_d = '0;
        if (clip_vel_q) begin
          vel_d   = vec_q;
          state_d = S_OUT;
        end else begin
          state_d = S_AL_GO;
        end
      end
      S_AL_GO: begin
        mul_start = 1'b1;
        mul_b     = {16'd0, alpha_q};
        state_d   = S_AL_WAIT;
      end
      S_AL_WAIT: begin
        if (mul_stat.done) begin
          qv   = (mul_prod + 64'd32768) >> 16;
          term = cur[31] ? $signed(64'd0 - qv) : $signed(qv);
          pos_d[axis_q] = sat32(64'(pos_cur) + term);
          state_d = S_BE_MUL_GO;
        end
      end
      S_BE_MUL_GO: begin
        mul_start = 1'b1;
        mul_b     = {16'd0, beta_q};
        state_d   = S_BE_MUL_WAIT;
      end
      S_BE_MUL_WAIT: begin
        if (mul_stat.done) begin
          state_d = S_BE_DIV_GO;
        end
      end
      S_BE_DIV_GO: begin
        // round to nearest: add half of dt*16
        div_start = 1'b1;
        div_a     = mul_prod + {45'd0, dt_q, 3'd0};
        div_b     = {12'd0, dt_q, 4'd0};
        state_d   = S_BE_DIV_WAIT;
      end
      S_BE_DIV_WAIT: begin
        if (div_stat.done) begin
          term = cur[31] ? $signed(64'd0 - div_quo) : $signed(div_quo);
          vel_d[axis_q] = sat32(64'(vel_cur) + term);
          if (axis_q == 2'd2) begin
            axis_d  = '0;
            state_d = S_VLOAD;
          end else begin
            axis_d  = axis_q + 2'd1;
            state_d = S_AL_GO;
          end
        end
      end
      S_VLOAD: begin
        vec_d      = vel_q;
        clip_vel_d = 1'b1;
        sum_d      = '0;
        axis_d     = '0;
        state_d    = S_SQ_GO;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          est_pos_d   = pos_q;
          est_vel_d   = vel_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      primed_q    <= 1'b0;
      clip_vel_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      primed_q    <= primed_d;
      clip_vel_q  <= clip_vel_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      vel_q       <= vel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cam_q     <= cam_d;
    dt_q      <= dt_d;
    sum_q     <= sum_d;
    vec_q     <= vec_d;
    mp_q      <= mp_d;
    est_pos_q <= est_pos_d;
    est_vel_q <= est_vel_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign est_pos_x_o = est_pos_q[0];
  assign est_pos_y_o = est_pos_q[1];
  assign est_pos_z_o = est_pos_q[2];
  assign est_vel_x_o = est_vel_q[0];
  assign est_vel_y_o = est_vel_q[1];
  assign est_vel_z_o = est_vel_q[2];

  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier restarted while busy");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && out_stall_i)
      |=> $stable(est_vel_x_o) && out_valid_o)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

/* tb/sv/gated_alpha_beta_tracker_3d_test.sv */
// ----------------------------------------------------------------------------
// gated_alpha_beta_tracker_3d_test: self-checking bench for the 3-axis tracker
// Measurement requests are predicted by an in-bench fixed-point tracker and
// checked field by field against the estimates returned, under random gaps on
// both channels and across several gain, gate and speed limit settings.
// ----------------------------------------------------------------------------
`default_nettype none

module gated_alpha_beta_tracker_3d_test;
  import gabt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CycleLimit = 64'd20_000_000;
  localparam int unsigned     RandPerPhase = 104;
  localparam int unsigned     NumPhases = 8;

  typedef struct packed {
    logic [2:0][31:0] mp;
    logic [2:0][31:0] mv;
    logic             cam;
    logic [15:0]      dt;
  } meas_t;

  // est[0..2] position, est[3..5] velocity
  typedef logic [5:0][31:0] est_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [30:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic signed [31:0] meas_pos_x_i = '0, meas_pos_y_i = '0, meas_pos_z_i = '0;
  logic signed [31:0] meas_vel_x_i = '0, meas_vel_y_i = '0, meas_vel_z_i = '0;
  logic        camera_valid_i = 1'b0;
  logic [15:0] time_step_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [31:0] est_pos_x_o, est_pos_y_o, est_pos_z_o;
  logic signed [31:0] est_vel_x_o, est_vel_y_o, est_vel_z_o;

  gated_alpha_beta_tracker_3d dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- tracker
  longint unsigned alpha_q16, beta_q16, gate_q8, vmax_q8;
  longint          trk_pos [3];
  longint          trk_vel [3];
  bit              trk_primed;

  meas_t  meas_q [$];
  est_t   est_q  [$];
  int     errors = 0;
  int     n_sent = 0, n_checked = 0, n_cam = 0;
  bit     calm = 1'b0;
  longint unsigned cycles = 0;

  function automatic longint sat_q8(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned abs_q(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  // halves away from zero
  function automatic longint div_near(longint num, longint unsigned den);
    longint unsigned q;
    q = (abs_q(num) + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void limit_norm(inout longint v [3], input longint unsigned lim);
    longint unsigned sum, n, q;
    sum = 0;
    for (int i = 0; i < 3; i++) sum += abs_q(v[i]) * abs_q(v[i]);
    if (sum > lim * lim) begin
      n = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = (abs_q(v[i]) * lim) / n;
        v[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
  endfunction

  function automatic est_t track_update(meas_t m);
    longint          innov [3];
    longint unsigned dt;
    est_t            e;
    dt = (m.dt == 0) ? longint'(DtDefault) : longint'(m.dt);
    if (!trk_primed) begin
      for (int i = 0; i < 3; i++) begin
        trk_pos[i] = longint'(signed'(m.mp[i]));
        trk_vel[i] = longint'(signed'(m.mv[i]));
      end
      trk_primed = 1'b1;
    end else begin
      for (int i = 0; i < 3; i++)
        trk_pos[i] = sat_q8(trk_pos[i] + div_near(trk_vel[i] * longint'(dt), 4096));
      if (m.cam) begin
        for (int i = 0; i < 3; i++)
          innov[i] = sat_q8(longint'(signed'(m.mp[i])) - trk_pos[i]);
        limit_norm(innov, gate_q8);
        for (int i = 0; i < 3; i++) begin
          trk_pos[i] = sat_q8(trk_pos[i] + div_near(longint'(alpha_q16) * innov[i], 65536));
          trk_vel[i] = sat_q8(trk_vel[i] + div_near(longint'(beta_q16) * innov[i], dt * 16));
        end
      end
    end
    limit_norm(trk_vel, vmax_q8);
    for (int i = 0; i < 3; i++) begin
      e[i]   = trk_pos[i][31:0];
      e[3+i] = trk_vel[i][31:0];
    end
    return e;
  endfunction

  // -------------------------------------------------------------- stimulus
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(20, 4);
    return $urandom_range(300, 50);
  endfunction

  // request driver
  int in_gap = 0;
  always @(posedge clk_i) begin
    logic  nxt_valid;
    meas_t m;
    nxt_valid = in_valid_i;
    if (in_valid_i && !in_stall_o) begin
      m = '{mp: {meas_pos_z_i, meas_pos_y_i, meas_pos_x_i},
            mv: {meas_vel_z_i, meas_vel_y_i, meas_vel_x_i},
            cam: camera_valid_i, dt: time_step_i};
      est_q.push_back(track_update(m));
      n_sent++;
      if (m.cam) n_cam++;
      nxt_valid = 1'b0;
      in_gap = idle_len();
    end
    if (!nxt_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (meas_q.size() > 0) begin
        m = meas_q.pop_front();
        {meas_pos_z_i, meas_pos_y_i, meas_pos_x_i} <= m.mp;
        {meas_vel_z_i, meas_vel_y_i, meas_vel_x_i} <= m.mv;
        camera_valid_i <= m.cam;
        time_step_i <= m.dt;
        nxt_valid = 1'b1;
      end
    end
    in_valid_i <= nxt_valid;
  end

  // result monitor and output back-pressure
  string fname [6] = '{"est_pos_x", "est_pos_y", "est_pos_z",
                       "est_vel_x", "est_vel_y", "est_vel_z"};
  int out_hold = 0;
  always @(posedge clk_i) begin
    est_t got, exp_e;
    if (out_valid_o && !out_stall_i) begin
      got = {est_vel_z_o, est_vel_y_o, est_vel_x_o, est_pos_z_o, est_pos_y_o, est_pos_x_o};
      if (est_q.size() == 0) begin
        $display("%0t: estimate with no request outstanding, got %h", $time, got);
        errors++;
      end else begin
        exp_e = est_q.pop_front();
        n_checked++;
        for (int i = 0; i < 6; i++)
          if (got[i] !== exp_e[i]) begin
            $display("%0t: %s expected %0d actual %0d", $time, fname[i],
                     signed'(exp_e[i]), signed'(got[i]));
            errors++;
          end
      end
    end
    if (out_hold > 0) begin
      out_hold--;
      out_stall_i <= 1'b1;
    end else begin
      out_hold = idle_len();
      out_stall_i <= (out_hold > 0);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d estimates outstanding", cycles, est_q.size());
      $display("gated_alpha_beta_tracker_3d test failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [30:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_ALPHA: alpha_q16 = val[15:0];
      CFG_BETA:  beta_q16 = val[15:0];
      CFG_GATE:  gate_q8 = val;
      CFG_SPEED: vmax_q8 = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sampled on the falling edge so the driver's updates have settled
  task automatic drain();
    while (meas_q.size() > 0 || in_valid_i || est_q.size() > 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic meas_t mk(longint px, longint py, longint pz, longint vx,
                               longint vy, longint vz, bit cam, int dt);
    meas_t m;
    m.mp = {pz[31:0], py[31:0], px[31:0]};
    m.mv = {vz[31:0], vy[31:0], vx[31:0]};
    m.cam = cam;
    m.dt = dt[15:0];
    return m;
  endfunction

  function automatic logic [30:0] pick_lim();
    case ($urandom_range(4))
      0: return '0;
      1: return 31'h7FFFFFFF;
      2: return 31'($urandom_range(4096, 1));
      3: return 31'($urandom_range(200000, 1000));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(3))
      0: return '0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    longint tp [3];
    longint tv [3];
    meas_t  m;
    int     dt;

    alpha_q16 = AlphaReset;
    beta_q16  = BetaReset;
    gate_q8   = GateReset;
    vmax_q8   = SpeedReset;
    trk_primed = 1'b0;
    for (int i = 0; i < 3; i++) begin
      trk_pos[i] = 0;
      trk_vel[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset defaults: first request loads and speed-clips the velocity
    meas_q.push_back(mk(1000, -2000, 3000, 200000, -200000, 50000, 1, 0));
    meas_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    meas_q.push_back(mk(1100, -1900, 2900, 0, 0, 0, 1, 0));
    meas_q.push_back(mk(5000, 5000, 5000, 0, 0, 0, 1, 1));
    meas_q.push_back(mk(5100, 4900, 5000, 0, 0, 0, 1, 65535));
    meas_q.push_back(mk(2147483647, 2147483647, 2147483647, 0, 0, 0, 1, 4096));
    meas_q.push_back(mk(-2147483648, -2147483648, -2147483648, 0, 0, 0, 1, 4096));
    meas_q.push_back(mk(2147483647, -2147483648, 0, 2147483647, -2147483648, 0, 0, 65535));
    meas_q.push_back(mk(-2147483648, 2147483647, -1, -1, -1, -1, 1, 0));
    meas_q.push_back(mk(10, 20, 30, 0, 0, 0, 1, 1));
    drain();

    // directed: full gains, zero gate and zero speed, then widest limits
    write_reg(CFG_ALPHA, {15'h7FFF, 16'hFFFF});
    write_reg(CFG_BETA, {15'h5555, 16'hFFFF});
    write_reg(CFG_GATE, '0);
    write_reg(CFG_SPEED, '0);
    meas_q.push_back(mk(90000, -90000, 1, 5, 5, 5, 1, 100));
    meas_q.push_back(mk(0, 0, 0, 0, 0, 0, 1, 0));
    meas_q.push_back(mk(3, 3, 3, 0, 0, 0, 0, 7));
    drain();
    write_reg(CFG_GATE, 31'h7FFFFFFF);
    write_reg(CFG_SPEED, 31'h7FFFFFFF);
    meas_q.push_back(mk(2147483647, 2147483647, 2147483647, 0, 0, 0, 1, 1));
    meas_q.push_back(mk(-2147483648, -2147483648, -2147483648, 0, 0, 0, 1, 1));
    meas_q.push_back(mk(0, 0, 0, 0, 0, 0, 1, 65535));
    meas_q.push_back(mk(123456, -654321, 777, 0, 0, 0, 1, 0));
    drain();

    for (int i = 0; i < 3; i++) begin
      tp[i] = trk_pos[i] >>> 4;
      tv[i] = int'($urandom_range(20000)) - 10000;
    end
    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        write_reg(CFG_ALPHA, {15'($urandom), pick_gain()});
        write_reg(CFG_BETA, {15'($urandom), pick_gain()});
        write_reg(CFG_GATE, pick_lim());
        write_reg(CFG_SPEED, pick_lim());
      end
      calm = (ph % 3 == 2);
      for (int k = 0; k < RandPerPhase; k++) begin
        if ($urandom_range(99) < 78) begin
          // a plausible track: noisy measurements around a moving target
          dt = ($urandom_range(9) == 0) ? 0 : $urandom_range(2000, 1);
          for (int i = 0; i < 3; i++) begin
            if ($urandom_range(19) == 0) tv[i] = int'($urandom_range(40000)) - 20000;
            tp[i] = tp[i] + ((tv[i] * dt) >>> 12);
            if (tp[i] > 64'sd1000000000 || tp[i] < -64'sd1000000000) tp[i] = 0;
          end
          m = mk(tp[0] + $urandom_range(8000) - 4000, tp[1] + $urandom_range(8000) - 4000,
                 tp[2] + $urandom_range(8000) - 4000, $urandom, $urandom, $urandom,
                 $urandom_range(99) < 80, dt);
        end else begin
          m = meas_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom});
        end
        meas_q.push_back(m);
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    $display("%0d requests sent (%0d with camera), %0d estimates checked over %0d phases",
             n_sent, n_cam, n_checked, NumPhases + 3);
    if (errors == 0 && est_q.size() == 0) begin
      $display("gated_alpha_beta_tracker_3d test passed");
    end else begin
      $display("%0d mismatches, %0d estimates still expected", errors, est_q.size());
      $display("gated_alpha_beta_tracker_3d test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/gabt_pkg.sv
rtl/core/gabt_mul.sv
rtl/core/gabt_div.sv
rtl/core/gabt_sqrt.sv
rtl/core/gated_alpha_beta_tracker_3d.sv
tb/sv/gated_alpha_beta_tracker_3d_test.sv
